>>> sv/onb_pkg.sv
// ----------------------------------------------------------------------------
// onb_pkg - shared types and constants for the orthonormal basis block
// Component word type and fixed sizes used by the basis pipeline.
// ----------------------------------------------------------------------------
package onb_pkg;

  // one vector component on the ports
  localparam int unsigned COMP_W = 16;

  // magnitude of the product of two components: at most 2^30
  localparam int unsigned MAG_W = 31;

  // quotient bits resolved by each divider stage
  localparam int unsigned DIV_STEP = 2;

  typedef logic signed [COMP_W-1:0] comp_t;

endpackage

>>> sv/orthonormal_basis_from_normal.sv
// ----------------------------------------------------------------------------
// orthonormal_basis_from_normal - tangent frame from a unit normal
// Forms a = 1/(1+|z|) in a pipelined restoring divider, scales x*x, y*y and
// x*y by it, then builds and saturates the two tangent vectors.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | words
//  ---------+---------------------+------------------------------------------
//  normal   | start / busy        | normal_x_i, normal_y_i, normal_z_i
//  basis    | done_o (one cycle)  | tangent_{x,y,z}_o, bitangent_{x,y,z}_o
//
//  A new normal is taken every cycle; busy stays low.
//  The pipeline runs through an entry stage, NDS = ceil((FRAC_BITS+1)/2)
//  divider stages, and the scale, round and output stages.
//  The divider chain resolves two quotient bits a stage.
//  Reset clears the valid bits only; words in flight are dropped.
//  The receiver cannot stall, so the pipeline never holds.
//
module orthonormal_basis_from_normal #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  onb_pkg::comp_t normal_x_i,
  input  onb_pkg::comp_t normal_y_i,
  input  onb_pkg::comp_t normal_z_i,
  output logic           done_o,
  output onb_pkg::comp_t tangent_x_o,
  output onb_pkg::comp_t tangent_y_o,
  output onb_pkg::comp_t tangent_z_o,
  output onb_pkg::comp_t bitangent_x_o,
  output onb_pkg::comp_t bitangent_y_o,
  output onb_pkg::comp_t bitangent_z_o
);

  import onb_pkg::*;

  // quotient bits, divider stages, and datapath widths
  localparam int unsigned QB  = FRAC_BITS + 1;
  localparam int unsigned NDS = (QB + DIV_STEP - 1) / DIV_STEP;
  localparam int unsigned DW  = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 2;
  localparam int unsigned PW  = MAG_W + QB;
  localparam int unsigned RW  = PW + 1 - 2 * FRAC_BITS;
  localparam int unsigned SW  = ((RW > FRAC_BITS + 2) ? RW : FRAC_BITS + 2) + 2;
  localparam int unsigned LAT = NDS + 4;

  localparam logic [PW:0] HALF = (PW + 1)'(1) << (2 * FRAC_BITS - 1);
  localparam logic signed [SW-1:0] ONE_S = {{(SW - FRAC_BITS - 1){1'b0}}, 1'b1,
                                            {FRAC_BITS{1'b0}}};
  localparam comp_t LIM_C = (FRAC_BITS < 15) ? COMP_W'(1 << FRAC_BITS)
                                             : COMP_W'(32767);
  localparam logic signed [SW-1:0] LIM_S = SW'(LIM_C);

  // clamp to [-L, L]
  function automatic comp_t sat_c(input logic signed [SW-1:0] v);
    comp_t res;
    if (v > LIM_S) begin
      res = LIM_C;
    end else if (v < -LIM_S) begin
      res = -LIM_C;
    end else begin
      res = v[COMP_W-1:0];
    end
    return res;
  endfunction

  // never holds off the source
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Entry stage: denominator, dividend, products
  // --------------------------------------------------------------------------
  logic [COMP_W-1:0]    z_u;
  logic [COMP_W-1:0]    z_abs;
  logic [DW-1:0]        d_in;
  logic [2*FRAC_BITS:0] num_in;
  logic [31:0]          pxx, pyy, pxy, pxy_abs;

  always_comb begin
    z_u     = normal_z_i;
    z_abs   = z_u[COMP_W-1] ? COMP_W'(~z_u + 16'd1) : z_u;
    d_in    = (DW'(1) << FRAC_BITS) + DW'(z_abs);
    // 2^2F + D/2: D/2 sits below the top bit, so no add
    num_in  = {1'b1, (2 * FRAC_BITS)'(d_in >> 1)};
    pxx     = 32'(normal_x_i * normal_x_i);
    pyy     = 32'(normal_y_i * normal_y_i);
    pxy     = 32'(normal_x_i * normal_y_i);
    pxy_abs = pxy[31] ? (~pxy + 32'd1) : pxy;
  end

  // pipeline words, index 0 is the entry stage, NDS the divider output
  logic             v_q   [NDS+1];
  comp_t            x_q   [NDS+1];
  comp_t            y_q   [NDS+1];
  logic             neg_q [NDS+1];
  logic             sxy_q [NDS+1];
  logic [MAG_W-1:0] mxx_q [NDS+1];
  logic [MAG_W-1:0] myy_q [NDS+1];
  logic [MAG_W-1:0] mxy_q [NDS+1];
  logic [DW-1:0]    d_q   [NDS+1];
  logic [DW-1:0]    r_q   [NDS+1];
  logic [QB-1:0]    n_q   [NDS+1];
  logic [QB-1:0]    q_q   [NDS+1];

  // --------------------------------------------------------------------------
  // Divider stages: restoring division, DIV_STEP quotient bits each
  // --------------------------------------------------------------------------
  logic [DW-1:0] r_d [NDS];
  logic [QB-1:0] n_d [NDS];
  logic [QB-1:0] q_d [NDS];

  always_comb begin
    logic [DW:0] trial;
    trial = '0;
    for (int s = 0; s < NDS; s++) begin
      r_d[s] = r_q[s];
      n_d[s] = n_q[s];
      q_d[s] = q_q[s];
      for (int k = 0; k < DIV_STEP; k++) begin
        if (s * DIV_STEP + k < QB) begin
          trial  = {r_d[s], n_d[s][QB-1]};
          n_d[s] = n_d[s] << 1;
          if (trial >= {1'b0, d_q[s]}) begin
            r_d[s] = DW'(trial - {1'b0, d_q[s]});
            q_d[s] = {q_d[s][QB-2:0], 1'b1};
          end else begin
            r_d[s] = trial[DW-1:0];
            q_d[s] = {q_d[s][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  // valid bits of entry and divider stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NDS; s++) begin
        v_q[s] <= 1'b0;
      end
    end else begin
      v_q[0] <= start && !busy;
      for (int s = 0; s < NDS; s++) begin
        v_q[s+1] <= v_q[s];
      end
    end
  end

  // words of entry and divider stages
  always_ff @(posedge clk_i) begin
    x_q[0]   <= normal_x_i;
    y_q[0]   <= normal_y_i;
    neg_q[0] <= normal_z_i[COMP_W-1];
    sxy_q[0] <= pxy[31];
    mxx_q[0] <= pxx[MAG_W-1:0];
    myy_q[0] <= pyy[MAG_W-1:0];
    mxy_q[0] <= pxy_abs[MAG_W-1:0];
    d_q[0]   <= d_in;
    r_q[0]   <= DW'(num_in[2*FRAC_BITS:QB]);
    n_q[0]   <= num_in[QB-1:0];
    q_q[0]   <= '0;
    for (int s = 0; s < NDS; s++) begin
      x_q[s+1]   <= x_q[s];
      y_q[s+1]   <= y_q[s];
      neg_q[s+1] <= neg_q[s];
      sxy_q[s+1] <= sxy_q[s];
      mxx_q[s+1] <= mxx_q[s];
      myy_q[s+1] <= myy_q[s];
      mxy_q[s+1] <= mxy_q[s];
      d_q[s+1]   <= d_q[s];
      r_q[s+1]   <= r_d[s];
      n_q[s+1]   <= n_d[s];
      q_q[s+1]   <= q_d[s];
    end
  end

  // --------------------------------------------------------------------------
  // Scale stage: products times the reciprocal
  // --------------------------------------------------------------------------
  logic          mul_v_q;
  comp_t         mul_x_q, mul_y_q;
  logic          mul_neg_q, mul_sxy_q;
  logic [PW-1:0] pm_xx_q, pm_yy_q, pm_xy_q;

  always_ff @(posedge clk_i) begin
    mul_x_q   <= x_q[NDS];
    mul_y_q   <= y_q[NDS];
    mul_neg_q <= neg_q[NDS];
    mul_sxy_q <= sxy_q[NDS];
    pm_xx_q   <= PW'(mxx_q[NDS]) * PW'(q_q[NDS]);
    pm_yy_q   <= PW'(myy_q[NDS]) * PW'(q_q[NDS]);
    pm_xy_q   <= PW'(mxy_q[NDS]) * PW'(q_q[NDS]);
  end

  // --------------------------------------------------------------------------
  // Round stage: half-up on magnitudes gives ties away from zero
  // --------------------------------------------------------------------------
  logic                 rnd_v_q;
  comp_t                rnd_x_q, rnd_y_q;
  logic                 rnd_neg_q;
  logic signed [SW-1:0] x2_q, y2_q, m_q;
  logic [PW:0]          sum_xx, sum_yy, sum_xy;
  logic signed [SW-1:0] x2_d, y2_d, m_d, m_abs;

  always_comb begin
    sum_xx = {1'b0, pm_xx_q} + HALF;
    sum_yy = {1'b0, pm_yy_q} + HALF;
    sum_xy = {1'b0, pm_xy_q} + HALF;
    x2_d   = signed'(SW'(sum_xx[PW:2*FRAC_BITS]));
    y2_d   = signed'(SW'(sum_yy[PW:2*FRAC_BITS]));
    m_abs  = signed'(SW'(sum_xy[PW:2*FRAC_BITS]));
    m_d    = mul_sxy_q ? -m_abs : m_abs;
  end

  always_ff @(posedge clk_i) begin
    rnd_x_q   <= mul_x_q;
    rnd_y_q   <= mul_y_q;
    rnd_neg_q <= mul_neg_q;
    x2_q      <= x2_d;
    y2_q      <= y2_d;
    m_q       <= m_d;
  end

  // --------------------------------------------------------------------------
  // Output stage: branch on the sign of z, saturate
  // --------------------------------------------------------------------------
  logic  done_q;
  comp_t tx_q, ty_q, tz_q, bx_q, by_q, bz_q;
  logic signed [SW-1:0] xs, ys;

  always_comb begin
    xs = SW'(rnd_x_q);
    ys = SW'(rnd_y_q);
  end

  always_ff @(posedge clk_i) begin
    tx_q <= sat_c(ONE_S - x2_q);
    ty_q <= sat_c(-m_q);
    tz_q <= sat_c(rnd_neg_q ? xs : -xs);
    bx_q <= sat_c(rnd_neg_q ? m_q : -m_q);
    by_q <= sat_c(rnd_neg_q ? (y2_q - ONE_S) : (ONE_S - y2_q));
    bz_q <= sat_c(-ys);
  end

  // valid bits of the tail stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
      rnd_v_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      mul_v_q <= v_q[NDS];
      rnd_v_q <= mul_v_q;
      done_q  <= rnd_v_q;
    end
  end

  assign done_o        = done_q;
  assign tangent_x_o   = tx_q;
  assign tangent_y_o   = ty_q;
  assign tangent_z_o   = tz_q;
  assign bitangent_x_o = bx_q;
  assign bitangent_y_o = by_q;
  assign bitangent_z_o = bz_q;

`ifndef SYNTHESIS
  // every accepted word comes out on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("basis word lost in pipeline");

  // no result without a matching accept
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("basis word without a normal");

  // divider leaves a proper remainder and a reciprocal not above one
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NDS] |-> (r_q[NDS] < d_q[NDS]) && (q_q[NDS] <= (QB'(1) << FRAC_BITS)))
    else $error("divider remainder or quotient out of range");

  // saturation keeps components in range
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (tangent_x_o <= LIM_C) && (tangent_x_o >= -LIM_C)
            && (bitangent_y_o <= LIM_C) && (bitangent_y_o >= -LIM_C))
    else $error("component outside saturation limit");

  // the shared cross term appears in both vectors, same magnitude
  a_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (tangent_y_o == bitangent_x_o) || (tangent_y_o == -bitangent_x_o))
    else $error("cross term mismatch between tangents");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for orthonormal_basis_from_normal
// Streams unit, box-range and raw 16-bit normals into the block under four
// sender idle phases. A scoreboard predicts each tangent frame in fixed
// point and checks every basis word against it, in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
  import onb_pkg::*;

  localparam int unsigned FRAC      = 14;
  localparam longint      ONE       = longint'(1) << FRAC;
  localparam longint      LIMIT     = (ONE < 32767) ? ONE : 32767;
  localparam longint      HALF      = longint'(1) << (2 * FRAC - 1);
  localparam int          LATENCY   = (FRAC + 2) / 2 + 4;
  localparam int          PER_PHASE = 320;

  // six components of one basis word, in port order
  typedef comp_t basis_t [6];

  typedef struct {
    comp_t  nx;
    comp_t  ny;
    comp_t  nz;
    basis_t word;
  } frame_entry_t;

  // --------------------------------------------------------------------------
  // scoreboard: predicts the tangent frame and checks returned words
  // --------------------------------------------------------------------------
  class basis_scoreboard;
    frame_entry_t pending_frames [$];
    int           errors  = 0;
    int           noted   = 0;
    int           checked = 0;

    // p * recip / 2^(2F), nearest, ties away from zero
    function longint rescale(longint p, longint recip);
      longint unsigned mag;
      longint unsigned r;
      mag = (p < 0) ? longint'(-p) : p;
      r   = (mag * recip + HALF) >> (2 * FRAC);
      return (p < 0) ? -longint'(r) : longint'(r);
    endfunction

    function comp_t clamp(longint v);
      if (v > LIMIT) v = LIMIT;
      if (v < -LIMIT) v = -LIMIT;
      return v[COMP_W-1:0];
    endfunction

    function void frame_from_normal(comp_t x, comp_t y, comp_t z, output basis_t b);
      longint sx, sy, sz, den, recip, x2, y2, m;
      bit     neg;
      sx    = x;
      sy    = y;
      sz    = z;
      neg   = (sz < 0);
      den   = ONE + (neg ? -sz : sz);
      recip = ((longint'(1) << (2 * FRAC)) + (den >>> 1)) / den;
      x2    = rescale(sx * sx, recip);
      y2    = rescale(sy * sy, recip);
      m     = rescale(sx * sy, recip);
      b[0]  = clamp(ONE - x2);
      b[1]  = clamp(-m);
      b[2]  = clamp(neg ? sx : -sx);
      b[3]  = clamp(neg ? m : -m);
      b[4]  = clamp(neg ? y2 - ONE : ONE - y2);
      b[5]  = clamp(-sy);
    endfunction

    function string field_name(int i);
      case (i)
        0: return "tangent_x";
        1: return "tangent_y";
        2: return "tangent_z";
        3: return "bitangent_x";
        4: return "bitangent_y";
        default: return "bitangent_z";
      endcase
    endfunction

    function void note_normal(comp_t x, comp_t y, comp_t z);
      frame_entry_t e;
      e.nx = x;
      e.ny = y;
      e.nz = z;
      frame_from_normal(x, y, z, e.word);
      pending_frames.push_back(e);
      noted++;
    endfunction

    function void check_basis(basis_t got);
      frame_entry_t e;
      if (pending_frames.size() == 0) begin
        errors++;
        if (errors <= 10) $display("mismatch: basis word with no normal outstanding");
        return;
      end
      e = pending_frames.pop_front();
      checked++;
      for (int i = 0; i < 6; i++) begin
        if (got[i] !== e.word[i]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch %s: normal (%0d, %0d, %0d) expected %0d, got %0d",
                     field_name(i), e.nx, e.ny, e.nz, e.word[i], got[i]);
        end
      end
    endfunction

    function int pending();
      return pending_frames.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and ports
  // --------------------------------------------------------------------------
  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start  = 1'b0;
  logic  busy;
  comp_t normal_x_i = '0;
  comp_t normal_y_i = '0;
  comp_t normal_z_i = '0;
  logic  done_o;
  comp_t tangent_x_o, tangent_y_o, tangent_z_o;
  comp_t bitangent_x_o, bitangent_y_o, bitangent_z_o;

  basis_scoreboard sb = new();
  int              idle_pct = 0;

  always #1 clk_i = ~clk_i;

  orthonormal_basis_from_normal #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .normal_x_i   (normal_x_i),
    .normal_y_i   (normal_y_i),
    .normal_z_i   (normal_z_i),
    .done_o       (done_o),
    .tangent_x_o  (tangent_x_o),
    .tangent_y_o  (tangent_y_o),
    .tangent_z_o  (tangent_z_o),
    .bitangent_x_o(bitangent_x_o),
    .bitangent_y_o(bitangent_y_o),
    .bitangent_z_o(bitangent_z_o)
  );

  // monitor: note accepted normals, check returned basis words
  always @(posedge clk_i) begin
    basis_t got;
    if (rst_ni) begin
      if (start && !busy) sb.note_normal(normal_x_i, normal_y_i, normal_z_i);
      if (done_o) begin
        got[0] = tangent_x_o;
        got[1] = tangent_y_o;
        got[2] = tangent_z_o;
        got[3] = bitangent_x_o;
        got[4] = bitangent_y_o;
        got[5] = bitangent_z_o;
        sb.check_basis(got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // driving tasks
  // --------------------------------------------------------------------------
  // start low, noise on the data lines
  task automatic idle_for(int n);
    repeat (n) begin
      start      <= 1'b0;
      normal_x_i <= comp_t'($urandom);
      normal_y_i <= comp_t'($urandom);
      normal_z_i <= comp_t'($urandom);
      @(posedge clk_i);
    end
  endtask

  // offer one normal and hold it until taken; each cycle idles at idle_pct
  task automatic send_normal(comp_t x, comp_t y, comp_t z);
    while ($urandom_range(99) < idle_pct) idle_for(1);
    start      <= 1'b1;
    normal_x_i <= x;
    normal_y_i <= y;
    normal_z_i <= z;
    do @(posedge clk_i); while (busy);
  endtask

  // sender holds off until every outstanding word is back
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic int signed_pick(int mag);
    return ($urandom_range(1) != 0) ? -mag : mag;
  endfunction

  // a random near-unit normal, one component rounded from the remainder
  task automatic send_unit_normal();
    int  ux, uy, uz, ymax, t;
    ux   = $urandom_range(16384);
    ymax = $rtoi($sqrt($itor(268435456 - ux * ux)));
    uy   = $urandom_range(ymax);
    uz   = $rtoi($sqrt($itor(268435456 - ux * ux - uy * uy)) + 0.5);
    if ($urandom_range(1) != 0) begin
      t  = ux;
      ux = uy;
      uy = t;
    end
    if ($urandom_range(3) == 0) begin
      t  = ux;
      ux = uz;
      uz = t;
    end
    send_normal(comp_t'(signed_pick(ux)), comp_t'(signed_pick(uy)),
                comp_t'(signed_pick(uz)));
  endtask

  task automatic send_random_normal();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) begin
      send_unit_normal();
    end else if (sel < 85) begin
      send_normal(comp_t'($urandom_range(32768) - 16384),
                  comp_t'($urandom_range(32768) - 16384),
                  comp_t'($urandom_range(32768) - 16384));
    end else begin
      send_normal(comp_t'($urandom), comp_t'($urandom), comp_t'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int pcts [4];
    pcts = '{0, 56, 0, 36};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: poles, equator, diagonals, zero z, smallest negative z, raw extremes
    send_normal(0, 0, 16384);
    send_normal(0, 0, -16384);
    send_normal(16384, 0, 0);
    send_normal(-16384, 0, 0);
    send_normal(0, 16384, 0);
    send_normal(0, -16384, 0);
    send_normal(11585, 11585, 0);
    send_normal(-11585, 11585, 0);
    send_normal(9459, 9459, 9459);
    send_normal(-9459, -9459, -9459);
    send_normal(0, 0, -1);
    send_normal(16384, 16384, -1);
    send_normal(32767, 32767, 32767);
    send_normal(-32768, -32768, -32768);
    send_normal(-32768, 0, 16384);
    send_normal(0, -32768, -16384);
    send_normal(32767, -32768, 0);
    send_normal(0, 0, 0);
    send_normal(1, -1, -32768);
    send_normal(-16384, 16384, -16384);
    send_normal(8192, -14189, 0);
    drain();

    // random phases under the sender idle rates listed in pcts
    foreach (pcts[p]) begin
      idle_pct = pcts[p];
      repeat (PER_PHASE) send_random_normal();
      drain();
    end

    sb.errors += sb.pending();
    $display("summary: %0d normals (directed poles, equator, raw extremes, random) sent",
             sb.noted);
    $display("summary: %0d basis words checked under four idle settings, %0d errors",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
